FILE: rtl/tga_rle_pkg.sv
// ---------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants of the TGA run-length pixel decoder.
// ---------------------------------------------------------------------------
package tga_rle_pkg;

   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned BPP_W   = 3;
   localparam int unsigned LANE_W  = 2;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] REG_PIXEL_COUNT     = 2'd1;
   localparam logic [1:0] REG_SWAP_RED_BLUE   = 2'd2;

   localparam logic [BPP_W-1:0]  BPP_RESET   = 3'd4;
   localparam logic [DATA_W-1:0] COUNT_RESET = 32'd1;
   localparam logic              SWAP_RESET  = 1'b1;

   localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
   localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;
   localparam logic [BPP_W-1:0] BPP_RGB = 3'd3;

   // header byte: bit 7 marks a run packet, low seven bits are count minus one
   localparam int unsigned RUN_BIT = 7;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [COUNT_W-1:0] repeat_count;
      logic               frame_end;
   } rsp_type;

   // clamp the depth register to 1..4 bytes
   function automatic logic [BPP_W-1:0] depth_bytes(input logic [BPP_W-1:0] bpp);
      logic [BPP_W-1:0] res;
      res = bpp;
      if (bpp == '0) begin
         res = BPP_MIN;
      end else if (bpp > BPP_MAX) begin
         res = BPP_MAX;
      end
      return res;
   endfunction

endpackage

FILE: rtl/tga_rle_pixel_decoder_top.sv
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA run-length packet decoder: bytes in, pixels with repeat counts out.
//
// The req channel takes one stream byte per item, header or pixel byte;
// req_frame_start marks the first header of a frame and restarts decoding.
// The rsp channel gives one item per raw pixel, or one per run packet with
// its repeat count, clipped to the pixels left in the frame. rsp_frame_end
// flags the item that completes the frame; later bytes are dropped until the
// next frame start. Both channels use valid/stall.
// Throughput is one byte per cycle while req_stall is low. A pixel item is
// registered once its last byte is accepted, in the skid register if rsp is
// held; all decode work sits between the packet state and result registers.
// A two-entry output (result register plus skid register) lets bytes keep
// flowing while rsp is stalled; req_stall rises only once both are full.
// Synchronous reset clears both entries, restores the registers to their
// defaults (4 bytes per pixel, 1 pixel, red/blue swap on) and starts a frame.
// User must write registers over the APB port only while idle; not enforced.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tga_rle_pkg::ADDR_W-1:0]      paddr,
   input  logic [tga_rle_pkg::DATA_W-1:0]      pwdata,
   output logic [tga_rle_pkg::DATA_W-1:0]      prdata,
   output logic                                pready,
   // byte stream
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_frame_start,
   // pixels
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tga_rle_pkg::PIXEL_W-1:0]     rsp_pixel_value,
   output logic [tga_rle_pkg::COUNT_W-1:0]     rsp_repeat_count,
   output logic                                rsp_frame_end
);

   localparam int unsigned PW = tga_rle_pkg::PIXEL_W;
   localparam int unsigned CW = tga_rle_pkg::COUNT_W;
   localparam int unsigned BW = tga_rle_pkg::BPP_W;
   localparam int unsigned LW = tga_rle_pkg::LANE_W;

   // configuration registers
   logic [BW-1:0] bpp_ff,   bpp_in;
   logic [PW-1:0] count_ff, count_in;
   logic          swap_ff,  swap_in;

   // packet state
   logic          in_header_ff,  in_header_in;
   logic          run_packet_ff, run_packet_in;
   logic [CW-1:0] pkt_left_ff,   pkt_left_in;
   logic [LW-1:0] lane_ff,       lane_in;
   logic [PW-1:0] assembly_ff,   assembly_in;
   logic [PW-1:0] frame_left_ff, frame_left_in;
   logic          frame_done_ff, frame_done_in;

   // output entries
   logic                 rsp_valid_ff,  rsp_valid_in;
   tga_rle_pkg::rsp_type rsp_ff,        rsp_in;
   logic                 skid_valid_ff, skid_valid_in;
   tga_rle_pkg::rsp_type skid_ff,       skid_in;

   logic                 cfg_write;
   logic [1:0]           cfg_index;
   logic                 req_take;
   logic                 rsp_take;
   logic                 new_valid;
   tga_rle_pkg::rsp_type new_rsp;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = paddr[3:2];

   always_comb begin
      bpp_in   = bpp_ff;
      count_in = count_ff;
      swap_in  = swap_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            tga_rle_pkg::REG_BYTES_PER_PIXEL: bpp_in   = pwdata[BW-1:0];
            tga_rle_pkg::REG_PIXEL_COUNT:     count_in = pwdata;
            tga_rle_pkg::REG_SWAP_RED_BLUE:   swap_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         tga_rle_pkg::REG_BYTES_PER_PIXEL: prdata = {{(32-BW){1'b0}}, bpp_ff};
         tga_rle_pkg::REG_PIXEL_COUNT:     prdata = count_ff;
         tga_rle_pkg::REG_SWAP_RED_BLUE:   prdata = {31'd0, swap_ff};
         default:                          prdata = '0;
      endcase
   end

   // ---------------- decode ----------------
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      logic          f_header;
      logic          f_run;
      logic [CW-1:0] f_left;
      logic [LW-1:0] f_lane;
      logic [PW-1:0] f_asm;
      logic [PW-1:0] f_frame;
      logic          f_done;
      logic [BW-1:0] depth;
      logic [PW-1:0] asm_next;
      logic [PW-1:0] pix;
      logic [CW-1:0] rep;
      logic [CW-1:0] left_next;
      logic [PW-1:0] frame_next;

      // frame start restarts the frame before this byte is decoded
      f_header = req_frame_start ? 1'b1 : in_header_ff;
      f_run    = req_frame_start ? 1'b0 : run_packet_ff;
      f_left   = req_frame_start ? '0   : pkt_left_ff;
      f_lane   = req_frame_start ? '0   : lane_ff;
      f_asm    = req_frame_start ? '0   : assembly_ff;
      f_frame  = req_frame_start ? count_ff : frame_left_ff;
      f_done   = req_frame_start ? (count_ff == '0) : frame_done_ff;

      depth    = tga_rle_pkg::depth_bytes(bpp_ff);
      asm_next = f_asm;
      asm_next[8*f_lane +: 8] = f_asm[8*f_lane +: 8] | req_data_byte;

      pix = asm_next;
      if (swap_ff && depth >= tga_rle_pkg::BPP_RGB) begin
         pix = {asm_next[31:24], asm_next[7:0], asm_next[15:8], asm_next[23:16]};
      end

      // run repeats are clipped to what is left of the frame
      if (f_run) begin
         rep       = (f_frame < {{(PW-CW){1'b0}}, f_left}) ? f_frame[CW-1:0] : f_left;
         left_next = '0;
      end else begin
         rep       = CW'(1);
         left_next = f_left - CW'(1);
      end
      frame_next = f_frame - {{(PW-CW){1'b0}}, rep};

      in_header_in  = f_header;
      run_packet_in = f_run;
      pkt_left_in   = f_left;
      lane_in       = f_lane;
      assembly_in   = f_asm;
      frame_left_in = f_frame;
      frame_done_in = f_done;
      new_valid     = 1'b0;
      new_rsp.pixel_value  = pix;
      new_rsp.repeat_count = rep;
      new_rsp.frame_end    = (frame_next == '0);

      if (!req_take) begin
         in_header_in  = in_header_ff;
         run_packet_in = run_packet_ff;
         pkt_left_in   = pkt_left_ff;
         lane_in       = lane_ff;
         assembly_in   = assembly_ff;
         frame_left_in = frame_left_ff;
         frame_done_in = frame_done_ff;
      end else if (f_done) begin
         // frame complete: byte dropped
      end else if (f_header) begin
         run_packet_in = req_data_byte[tga_rle_pkg::RUN_BIT];
         pkt_left_in   = {1'b0, req_data_byte[6:0]} + CW'(1);
         in_header_in  = 1'b0;
         lane_in       = '0;
         assembly_in   = '0;
      end else if ({1'b0, f_lane} + BW'(1) < depth) begin
         lane_in     = f_lane + LW'(1);
         assembly_in = asm_next;
      end else begin
         lane_in       = '0;
         assembly_in   = '0;
         pkt_left_in   = left_next;
         frame_left_in = frame_next;
         frame_done_in = (frame_next == '0);
         in_header_in  = (left_next == '0);
         new_valid     = 1'b1;
      end
   end

   // ---------------- output register and skid ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = new_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = rsp_ff.pixel_value;
   assign rsp_repeat_count = rsp_ff.repeat_count;
   assign rsp_frame_end    = rsp_ff.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= tga_rle_pkg::BPP_RESET;
         count_ff      <= tga_rle_pkg::COUNT_RESET;
         swap_ff       <= tga_rle_pkg::SWAP_RESET;
         in_header_ff  <= 1'b1;
         run_packet_ff <= 1'b0;
         pkt_left_ff   <= '0;
         lane_ff       <= '0;
         assembly_ff   <= '0;
         frame_left_ff <= tga_rle_pkg::COUNT_RESET;
         frame_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         bpp_ff        <= bpp_in;
         count_ff      <= count_in;
         swap_ff       <= swap_in;
         in_header_ff  <= in_header_in;
         run_packet_ff <= run_packet_in;
         pkt_left_ff   <= pkt_left_in;
         lane_ff       <= lane_in;
         assembly_ff   <= assembly_in;
         frame_left_ff <= frame_left_in;
         frame_done_ff <= frame_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   // ---------------- assertions ----------------
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.repeat_count != '0))
      else $error("result item with zero repeat count");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      frame_done_ff |-> (frame_left_ff == '0))
      else $error("frame marked done with pixels left");

   a_packet_live: assert property (@(posedge clock) disable iff (reset)
      (!in_header_ff && !frame_done_ff) |-> (pkt_left_ff != '0))
      else $error("packet body with no pixels left");

endmodule

FILE: tb/sv/tb_tga_rle_pixel_decoder_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_top
// Self-checking bench for the TGA run-length pixel decoder.
//
// A queue of stream bytes is built phase by phase. Each phase first sets the
// depth, pixel count and red/blue swap registers over APB, then adds frames of
// run and raw packets with random pixel bytes, some cut short, some with bytes
// past frame end. A clocked driver feeds the bytes with random gaps. Each
// accepted byte runs through a local decoder model that queues the expected
// pixels. A clocked monitor, under random stall, checks every pixel against
// the oldest one queued.
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_top;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } stream_byte_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [tga_rle_pkg::ADDR_W-1:0]      paddr = '0;
   logic [tga_rle_pkg::DATA_W-1:0]      pwdata = '0;
   logic [tga_rle_pkg::DATA_W-1:0]      prdata;
   logic                                pready;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_data_byte = '0;
   logic                                req_frame_start = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [tga_rle_pkg::PIXEL_W-1:0]     rsp_pixel_value;
   logic [tga_rle_pkg::COUNT_W-1:0]     rsp_repeat_count;
   logic                                rsp_frame_end;

   stream_byte_type      pending_bytes[$];
   tga_rle_pkg::rsp_type pixel_q[$];

   // decoder register and state copies
   logic [2:0]  cfg_bpp;
   logic [31:0] cfg_count;
   logic        cfg_swap;
   logic        hdr_wait;
   logic        run_pkt;
   logic [7:0]  pkt_left;
   logic [1:0]  lane;
   logic [31:0] assembly;
   logic [31:0] frame_left;
   logic        frame_over;

   int  mismatches = 0;
   int  stream_bytes = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;
   bit  quiet = 1'b0;

   tga_rle_pixel_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void open_frame();
      hdr_wait   = 1'b1;
      run_pkt    = 1'b0;
      pkt_left   = '0;
      lane       = '0;
      assembly   = '0;
      frame_left = cfg_count;
      frame_over = (cfg_count == 32'd0);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic start);
      int unsigned          depth;
      logic [31:0]          pix;
      logic [31:0]          rep;
      tga_rle_pkg::rsp_type want;
      if (start) begin
         open_frame();
      end
      if (frame_over) begin
         return;
      end
      if (hdr_wait) begin
         run_pkt  = b[tga_rle_pkg::RUN_BIT];
         pkt_left = {1'b0, b[6:0]} + 8'd1;
         hdr_wait = 1'b0;
         lane     = '0;
         assembly = '0;
         return;
      end
      // depth register is read live; out-of-range values clamp to 1..4
      depth = (cfg_bpp == 3'd0) ? 1 : (cfg_bpp > 3'd4) ? 4 : cfg_bpp;
      assembly = assembly | (32'(b) << (8 * lane));
      if (lane + 1 < depth) begin
         lane = lane + 2'd1;
         return;
      end
      pix = assembly;
      if (cfg_swap && depth >= 3) begin
         pix = {pix[31:24], pix[7:0], pix[15:8], pix[23:16]};
      end
      lane     = '0;
      assembly = '0;
      if (run_pkt) begin
         rep = 32'(pkt_left);
         if (rep > frame_left) begin
            rep = frame_left;
         end
         pkt_left = '0;
      end else begin
         rep = 32'd1;
         pkt_left = pkt_left - 8'd1;
      end
      frame_left = frame_left - rep;
      if (frame_left == 32'd0) begin
         frame_over = 1'b1;
      end
      if (pkt_left == 8'd0) begin
         hdr_wait = 1'b1;
      end
      want.pixel_value  = pix;
      want.repeat_count = rep[7:0];
      want.frame_end    = frame_over;
      pixel_q.push_back(want);
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic start);
      stream_byte_type it;
      it.data  = b;
      it.start = start;
      pending_bytes.push_back(it);
      stream_bytes++;
   endfunction

   // one frame of packets; a few are cut short, some get trailing bytes
   function automatic void gen_frame(input logic [31:0] count, input int depth);
      longint unsigned left;
      int              n;
      int              nb;
      int              budget;
      bit              first;
      bit              broken;
      left   = count;
      budget = 80;
      first  = 1'b1;
      broken = 1'b0;
      if (count == 32'd0) begin
         add_byte(8'($urandom), 1'b1);
         add_byte(8'($urandom), 1'b0);
         add_byte(8'($urandom), 1'b0);
         return;
      end
      while (left > 0 && budget > 0 && !broken) begin
         if ($urandom_range(0, 1) == 0) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            add_byte(8'h80 | 8'(n - 1), first);
            nb = depth;
         end else begin
            if (depth == 1 && $urandom_range(0, 5) == 0) begin
               n = $urandom_range(1, 128);
            end else begin
               n = $urandom_range(1, 6);
            end
            add_byte(8'(n - 1), first);
            nb = n * depth;
         end
         first = 1'b0;
         if ($urandom_range(0, 11) == 0) begin
            nb = $urandom_range(0, nb - 1);
            broken = 1'b1;
         end
         for (int k = 0; k < nb; k++) begin
            add_byte(8'($urandom), 1'b0);
         end
         left   = (n > left) ? 0 : left - n;
         budget = budget - nb - 1;
      end
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < $urandom_range(1, 3); k++) begin
            add_byte(8'($urandom), 1'b0);
         end
      end
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tga_rle_pkg::REG_BYTES_PER_PIXEL: cfg_bpp = value[2:0];
         tga_rle_pkg::REG_PIXEL_COUNT:     cfg_count = value;
         tga_rle_pkg::REG_SWAP_RED_BLUE:   cfg_swap = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [2:0] bpp, input logic [31:0] count,
                            input logic swap);
      csr_write(tga_rle_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
      csr_write(tga_rle_pkg::REG_PIXEL_COUNT, count);
      csr_write(tga_rle_pkg::REG_SWAP_RED_BLUE, 32'(swap));
   endtask

   // header bytes give no pixel, so the wait goes on after the last pixel is seen
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || pixel_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : byte_driver
      stream_byte_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_frame_start);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               it = pending_bytes.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= it.data;
               req_frame_start <= it.start;
               if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
                  gap_left = $urandom_range(1, 13);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : pixel_monitor
      tga_rle_pkg::rsp_type got;
      tga_rle_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pixel_value, rsp_repeat_count, rsp_frame_end};
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected pixel %h repeat %0d end %b", $realtime,
                        got.pixel_value, got.repeat_count, got.frame_end);
            end
         end else begin
            want = pixel_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: pixel %h/%h repeat %0d/%0d end %b/%b (exp/act)",
                           $realtime, want.pixel_value, got.pixel_value,
                           want.repeat_count, got.repeat_count,
                           want.frame_end, got.frame_end);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]  bpp;
      logic [31:0] count;
      int          depth;
      int          phase;
      cfg_bpp   = tga_rle_pkg::BPP_RESET;
      cfg_count = tga_rle_pkg::COUNT_RESET;
      cfg_swap  = tga_rle_pkg::SWAP_RESET;
      open_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no frame start yet: reset defaults act as a one-pixel frame
      add_byte(8'h80, 1'b0);
      add_byte(8'h11, 1'b0);
      add_byte(8'h22, 1'b0);
      add_byte(8'h33, 1'b0);
      add_byte(8'h44, 1'b0);
      add_byte(8'h55, 1'b0);
      wait_idle();

      // full-length run, a raw packet, then a run clipped at frame end
      configure(tga_rle_pkg::BPP_RGB, 32'd200, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_byte(8'h01, 1'b0);
      for (int k = 0; k < 6; k++) begin
         add_byte(8'(k * 8'h33), 1'b0);
      end
      add_byte(8'hFF, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(8'hC3, 1'b0);
      add_byte(8'h0F, 1'b0);
      add_byte(8'h7F, 1'b0);
      wait_idle();

      // empty frame: everything ignored
      csr_write(tga_rle_pkg::REG_PIXEL_COUNT, 32'd0);
      add_byte(8'h80, 1'b1);
      add_byte(8'h12, 1'b0);
      wait_idle();

      phase = 0;
      stream_bytes = 0;
      while (stream_bytes < 650) begin
         if (phase == 0) begin
            bpp = 3'd0;
            count = 32'hFFFF_FFFF;
         end else if (phase == 1) begin
            bpp = 3'd7;
            count = 32'd1;
         end else begin
            case ($urandom_range(0, 9))
               0:       bpp = 3'd0;
               1:       bpp = 3'd7;
               2:       bpp = 3'd5;
               default: bpp = 3'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 19))
               0:       count = 32'd0;
               1:       count = 32'hFFFF_FFFF;
               2, 3:    count = $urandom_range(150, 600);
               4:       count = 32'd1;
               default: count = $urandom_range(2, 24);
            endcase
         end
         depth = (bpp == 3'd0) ? 1 : (bpp > 3'd4) ? 4 : bpp;
         idle_on = ($urandom_range(0, 3) != 0);
         quiet = (stream_bytes >= 560);
         configure(bpp, count, 1'($urandom_range(0, 1)));
         for (int f = 0; f < $urandom_range(1, 3); f++) begin
            gen_frame(count, depth);
         end
         // stray bytes, some of them restarting the frame
         if ($urandom_range(0, 3) == 0) begin
            for (int k = 0; k < $urandom_range(1, 6); k++) begin
               add_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
         end
         wait_idle();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tga_rle_pkg.sv
rtl/tga_rle_pixel_decoder_top.sv
tb/sv/tb_tga_rle_pixel_decoder_top.sv
